@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define ASSERT_CLKRST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("spi engine check failed");

// concurrent check on the usual clk_i and rst_ni
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLKRST(lbl, clk_i, rst_ni, prop)

`endif

@@ design/spimbe_pkg.sv @@
// constants and types shared by the spi master byte engine files
package spimbe_pkg;

  localparam int unsigned WORD_BITS    = 8;
  localparam int unsigned DIV_BITS     = 16;
  localparam int unsigned MODE_BITS    = 2;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned HPC_BITS     = 5;
  // half periods in one exchange
  localparam logic [HPC_BITS-1:0] HALF_PERIODS = HPC_BITS'(2 * WORD_BITS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DIVISOR     = 2'd0,
    CFG_MODE        = 2'd1,
    CFG_LSB_FIRST   = 2'd2,
    CFG_CHIP_SELECT = 2'd3
  } cfg_idx_e;

endpackage

@@ design/spi_master_byte_engine_top.sv @@
// spi master byte engine: one tick per input beat, one result beat per tick
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | in
//  in      | in_valid_i in_ready_o cmd_i tx_byte_i miso_i  | in
//  out     | out_valid_o out_ready_i sclk_o mosi_o ...     | out
//
// the tick update is one pass from the state registers
// to the state and result registers, so a beat is taken every cycle
// while the result register is empty or being drained
// cfg_ready_o is always high; a register write takes effect the next cycle
// reset clears all state, registers and the result valid
// a stalled result holds and blocks the input only while out_ready_i is low
module spi_master_byte_engine_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [spimbe_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [spimbe_pkg::DIV_BITS-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   cmd_i,
  input  logic [spimbe_pkg::WORD_BITS-1:0]       tx_byte_i,
  input  logic                                   miso_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   sclk_o,
  output logic                                   mosi_o,
  output logic                                   cs_asserted_o,
  output logic                                   busy_res_o,
  output logic [spimbe_pkg::WORD_BITS-1:0]       rx_byte_o,
  output logic                                   done_res_o
);
  import spimbe_pkg::*;

  // configuration registers
  logic [DIV_BITS-1:0]  div_q;
  logic [MODE_BITS-1:0] mode_q;
  logic                 lsb_q;
  logic                 cs_q;

  // engine state
  logic [DIV_BITS-1:0]  tick_q, tick_d;
  logic [HPC_BITS-1:0]  hpc_q, hpc_d;
  logic [WORD_BITS-1:0] tx_q, tx_d;
  logic [WORD_BITS-1:0] rx_q, rx_d;
  logic [WORD_BITS-1:0] hold_q, hold_d;
  logic                 lvl_q, lvl_d;
  logic                 active_q, active_d;

  // result register
  logic                 out_valid_q;
  logic                 mosi_q, mosi_d;
  logic                 cs_out_q;
  logic                 done_q, done_d;

  logic                 accept;
  logic                 cpol, cpha;
  logic [HPC_BITS-1:0]  hpc_inc;
  logic                 leading;
  logic                 do_sample, do_shift;
  logic [WORD_BITS-1:0] rx_smp;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  assign cpol    = mode_q[1];
  assign cpha    = mode_q[0];
  assign hpc_inc = hpc_q + HPC_BITS'(1);
  assign leading = !hpc_q[0];

  always_comb begin
    do_sample = cpha ? !leading : leading;
    do_shift  = cpha ? (leading && (hpc_q != '0)) : !leading;
  end

  always_comb begin
    if (lsb_q) begin
      rx_smp = {miso_i, rx_q[WORD_BITS-1:1]};
    end else begin
      rx_smp = {rx_q[WORD_BITS-2:0], miso_i};
    end
  end

  always_comb begin
    tick_d   = tick_q;
    hpc_d    = hpc_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    hold_d   = hold_q;
    lvl_d    = lvl_q;
    active_d = active_q;
    done_d   = 1'b0;
    if (!active_q) begin
      lvl_d = cpol;
      if (cmd_i) begin
        tx_d     = tx_byte_i;
        rx_d     = '0;
        tick_d   = '0;
        hpc_d    = '0;
        active_d = 1'b1;
      end
    end else if (tick_q >= div_q) begin
      // sclk edge
      tick_d = '0;
      lvl_d  = !lvl_q;
      hpc_d  = hpc_inc;
      if (do_sample) begin
        rx_d = rx_smp;
      end
      if (do_shift) begin
        tx_d = lsb_q ? {1'b0, tx_q[WORD_BITS-1:1]} : {tx_q[WORD_BITS-2:0], 1'b0};
      end
      if (hpc_inc >= HALF_PERIODS) begin
        hold_d   = do_sample ? rx_smp : rx_q;
        active_d = 1'b0;
        hpc_d    = '0;
        lvl_d    = cpol;
        done_d   = 1'b1;
      end
    end else begin
      tick_d = tick_q + DIV_BITS'(1);
    end
  end

  always_comb begin
    if (!active_d) begin
      mosi_d = 1'b0;
    end else if (lsb_q) begin
      mosi_d = tx_d[0];
    end else begin
      mosi_d = tx_d[WORD_BITS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= '0;
      mode_q <= '0;
      lsb_q  <= 1'b0;
      cs_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DIVISOR:     div_q  <= cfg_data_i;
        CFG_MODE:        mode_q <= cfg_data_i[MODE_BITS-1:0];
        CFG_LSB_FIRST:   lsb_q  <= cfg_data_i[0];
        CFG_CHIP_SELECT: cs_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      hpc_q       <= '0;
      tx_q        <= '0;
      rx_q        <= '0;
      hold_q      <= '0;
      lvl_q       <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mosi_q      <= 1'b0;
      cs_out_q    <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (accept) begin
        tick_q      <= tick_d;
        hpc_q       <= hpc_d;
        tx_q        <= tx_d;
        rx_q        <= rx_d;
        hold_q      <= hold_d;
        lvl_q       <= lvl_d;
        active_q    <= active_d;
        mosi_q      <= mosi_d;
        cs_out_q    <= cs_q;
        done_q      <= done_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sclk_o        = lvl_q;
  assign mosi_o        = mosi_q;
  assign cs_asserted_o = cs_out_q;
  assign busy_res_o    = active_q;
  assign rx_byte_o     = hold_q;
  assign done_res_o    = done_q;

endmodule

@@ design/spimbe_checker.sv @@
// port-level checks for the spi master byte engine, bound to the top level
`include "assert_macros.svh"

module spimbe_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                mosi_o,
  input logic                                busy_res_o,
  input logic [spimbe_pkg::WORD_BITS-1:0]    rx_byte_o,
  input logic                                done_res_o
);
  import spimbe_pkg::*;

  // the exchange is over on the beat that reports done
  `ASSERT_DEF(done_not_busy, out_valid_o && done_res_o |-> !busy_res_o)
  // mosi rests low outside an exchange
  `ASSERT_DEF(idle_mosi_low, out_valid_o && !busy_res_o |-> !mosi_o)
  // an empty result register never blocks the input
  `ASSERT_DEF(empty_takes_input, !out_valid_o |-> in_ready_o)
  // a stalled result beat holds
  `ASSERT_DEF(stall_holds, out_valid_o && !out_ready_i |=>
    out_valid_o && $stable(rx_byte_o) && $stable(done_res_o))

endmodule

bind spi_master_byte_engine_top spimbe_checker u_spimbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .mosi_o      (mosi_o),
  .busy_res_o  (busy_res_o),
  .rx_byte_o   (rx_byte_o),
  .done_res_o  (done_res_o)
);

@@ test/spi_master_byte_engine_top_tb.sv @@
// testbench for the spi master byte engine: tick stimulus, pin predictor and result checks
`timescale 1ns / 1ps

module spi_master_byte_engine_top_tb;
  import spimbe_pkg::*;

  // one result beat as seen on the output port
  typedef struct packed {
    logic                 sclk;
    logic                 mosi;
    logic                 cs;
    logic                 busy;
    logic [WORD_BITS-1:0] rx;
    logic                 done;
  } pin_set_t;

  // tracks the engine state per accepted tick and checks the result beats
  class spi_tick_tracker;
    logic [DIV_BITS-1:0]  divisor;
    logic [MODE_BITS-1:0] mode;
    logic                 lsb;
    logic                 cs;

    logic [DIV_BITS-1:0]  tick_cnt;
    logic [HPC_BITS-1:0]  half_cnt;
    logic [WORD_BITS-1:0] tx_sr;
    logic [WORD_BITS-1:0] rx_sr;
    logic [WORD_BITS-1:0] rx_last;
    logic                 sclk_lvl;
    bit                   running;

    pin_set_t pending_pins[$];
    int       mismatches;

    function new();
      divisor    = '0;
      mode       = '0;
      lsb        = 1'b0;
      cs         = 1'b0;
      tick_cnt   = '0;
      half_cnt   = '0;
      tx_sr      = '0;
      rx_sr      = '0;
      rx_last    = '0;
      sclk_lvl   = 1'b0;
      running    = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [DIV_BITS-1:0] value);
      case (idx)
        CFG_DIVISOR: divisor = value;
        CFG_MODE: begin
          mode = value[MODE_BITS-1:0];
          if (!running) sclk_lvl = mode[1];
        end
        CFG_LSB_FIRST:   lsb = value[0];
        CFG_CHIP_SELECT: cs = value[0];
        default: ;
      endcase
    endfunction

    function void shift_tx();
      if (lsb) tx_sr = tx_sr >> 1;
      else tx_sr = tx_sr << 1;
    endfunction

    function void sample_rx(logic bit_in);
      if (lsb) rx_sr = {bit_in, rx_sr[WORD_BITS-1:1]};
      else rx_sr = {rx_sr[WORD_BITS-2:0], bit_in};
    endfunction

    // advance one tick and queue the pins expected after it
    function void note_tick(logic cmd, logic [WORD_BITS-1:0] tx, logic miso);
      logic [HPC_BITS-1:0] edge_no;
      bit                  lead;
      logic                done;
      pin_set_t            exp_pins;
      done = 1'b0;
      if (!running) begin
        sclk_lvl = mode[1];
        if (cmd) begin
          tx_sr    = tx;
          rx_sr    = '0;
          tick_cnt = '0;
          half_cnt = '0;
          running  = 1;
        end
      end else if (tick_cnt >= divisor) begin
        edge_no  = half_cnt;
        lead     = !edge_no[0];
        tick_cnt = '0;
        sclk_lvl = ~sclk_lvl;
        half_cnt = half_cnt + HPC_BITS'(1);
        if (!mode[0]) begin
          if (lead) sample_rx(miso);
          else shift_tx();
        end else begin
          if (lead) begin
            if (edge_no != '0) shift_tx();
          end else begin
            sample_rx(miso);
          end
        end
        if (half_cnt >= HALF_PERIODS) begin
          rx_last  = rx_sr;
          running  = 0;
          half_cnt = '0;
          sclk_lvl = mode[1];
          done     = 1'b1;
        end
      end else begin
        tick_cnt = tick_cnt + DIV_BITS'(1);
      end
      exp_pins.sclk = sclk_lvl;
      exp_pins.mosi = running ? (lsb ? tx_sr[0] : tx_sr[WORD_BITS-1]) : 1'b0;
      exp_pins.cs   = cs;
      exp_pins.busy = running;
      exp_pins.rx   = rx_last;
      exp_pins.done = done;
      pending_pins.push_back(exp_pins);
    endfunction

    function void check_pins(pin_set_t got);
      pin_set_t exp_pins;
      if (pending_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: sclk=%0b mosi=%0b cs=%0b busy=%0b",
                   got.sclk, got.mosi, got.cs, got.busy,
                   " rx=%02h done=%0b", got.rx, got.done);
        return;
      end
      exp_pins = pending_pins.pop_front();
      if (got.sclk !== exp_pins.sclk || got.mosi !== exp_pins.mosi ||
          got.cs !== exp_pins.cs || got.busy !== exp_pins.busy ||
          got.rx !== exp_pins.rx || got.done !== exp_pins.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t:", $realtime,
                   " exp sclk=%0b mosi=%0b cs=%0b busy=%0b rx=%02h done=%0b,",
                   exp_pins.sclk, exp_pins.mosi, exp_pins.cs, exp_pins.busy,
                   exp_pins.rx, exp_pins.done,
                   " got sclk=%0b mosi=%0b cs=%0b busy=%0b rx=%02h done=%0b",
                   got.sclk, got.mosi, got.cs, got.busy, got.rx, got.done);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [DIV_BITS-1:0]    cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   cmd_i;
  logic [WORD_BITS-1:0]   tx_byte_i;
  logic                   miso_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   sclk_o;
  logic                   mosi_o;
  logic                   cs_asserted_o;
  logic                   busy_res_o;
  logic [WORD_BITS-1:0]   rx_byte_o;
  logic                   done_res_o;

  spi_tick_tracker tracker = new();

  bit sender_idles;
  bit receiver_stalls;
  int hold_off_left;

  spi_master_byte_engine_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .tx_byte_i    (tx_byte_i),
    .miso_i       (miso_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sclk_o       (sclk_o),
    .mosi_o       (mosi_o),
    .cs_asserted_o(cs_asserted_o),
    .busy_res_o   (busy_res_o),
    .rx_byte_o    (rx_byte_o),
    .done_res_o   (done_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(64'd20_000_000);
    $display("[spi_master_byte_engine_top] ERROR");
    $finish;
  end

  // receiver side: random stalls plus a counted hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_ready_i <= 1'b0;
        hold_off_left--;
      end else if (receiver_stalls &&
                   $urandom_range(99) < (sender_idles ? 33 : 77)) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_pins({sclk_o, mosi_o, cs_asserted_o, busy_res_o, rx_byte_o, done_res_o});
  end

  task automatic send_tick(logic cmd, logic [WORD_BITS-1:0] tx, logic miso);
    while (sender_idles && $urandom_range(99) < (receiver_stalls ? 33 : 77)) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    tx_byte_i  <= tx;
    miso_i     <= miso;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    tracker.note_tick(cmd, tx, miso);
  endtask

  // start exchanges on about half of the idle ticks; some writes land mid exchange and must be ignored
  task automatic send_random_tick();
    logic cmd;
    if (!tracker.running) cmd = ($urandom_range(1) == 1);
    else cmd = ($urandom_range(9) == 0);
    send_tick(cmd, WORD_BITS'($urandom), 1'($urandom));
  endtask

  // wait until every beat so far has come back, then let the pipeline drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending_pins.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DIV_BITS-1:0] value);
    logic [DIV_BITS-1:0] data;
    // junk in the unused upper bits of the narrow registers
    data = value;
    if (idx != CFG_DIVISOR) data = (DIV_BITS'($urandom) & ~DIV_BITS'(3)) | (value & DIV_BITS'(3));
    if (idx == CFG_LSB_FIRST || idx == CFG_CHIP_SELECT) data[1] = 1'($urandom_range(1));
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [DIV_BITS-1:0] div_val;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_DIVISOR;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    cmd_i           = 1'b0;
    tx_byte_i       = '0;
    miso_i          = 1'b0;
    sender_idles    = 0;
    receiver_stalls = 0;
    hold_off_left   = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: divisor 0, mode 0, msb first, no chip select
    send_tick(1'b0, 8'h00, 1'b1);  // idle mosi stays low
    send_tick(1'b1, 8'hff, 1'b0);
    for (int i = 0; i < 16; i++)
      send_tick(i[2], 8'h00, i[0] ^ i[3]);  // writes while busy are ignored
    send_tick(1'b1, 8'h00, 1'b1);
    send_tick(1'b1, 8'h5a, 1'b1);
    for (int i = 0; i < 4; i++) send_tick(1'b0, 8'hff, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      sender_idles    = (ph % 4 == 1) || (ph % 4 == 3);
      receiver_stalls = (ph % 4 == 2) || (ph % 4 == 3);
      if (ph == 0) begin
        // slowest divisor, then cut it below the running tick count
        write_reg(CFG_DIVISOR, 16'hffff);
        write_reg(CFG_MODE, 16'd3);
        write_reg(CFG_LSB_FIRST, 16'd1);
        write_reg(CFG_CHIP_SELECT, 16'd1);
        send_tick(1'b1, WORD_BITS'($urandom), 1'b1);
        repeat (40) send_tick(1'b0, WORD_BITS'($urandom), 1'($urandom));
        settle();
        write_reg(CFG_DIVISOR, 16'd4);
      end else begin
        if (ph == 11) div_val = '0;
        else if (ph == 7) div_val = DIV_BITS'($urandom_range(12, 8));
        else div_val = DIV_BITS'($urandom_range(3));
        write_reg(CFG_DIVISOR, div_val);
        write_reg(CFG_MODE, DIV_BITS'((ph * 3) % 4));
        write_reg(CFG_LSB_FIRST, DIV_BITS'((ph >> 1) & 1));
        write_reg(CFG_CHIP_SELECT, DIV_BITS'(((ph >> 2) ^ ph) & 1));
      end
      if (ph == 5) begin
        // long receiver hold-off while the sender keeps offering
        sender_idles  = 0;
        hold_off_left = 60;
      end
      repeat (100) send_random_tick();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending_pins.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_pins.size() == 0) begin
      $display("[spi_master_byte_engine_top] OK");
    end else begin
      $display("[spi_master_byte_engine_top] ERROR");
    end
    $finish;
  end

endmodule

@@ spi_master_byte_engine_top.f @@
+incdir+design
design/spimbe_pkg.sv
design/spi_master_byte_engine_top.sv
design/spimbe_checker.sv
test/spi_master_byte_engine_top_tb.sv
